// ===== hw/rtl/pgw_pkg.sv =====
// Shared types and constants for the four-level page table walker.
`timescale 1ns / 1ps
`default_nettype none

package pgw_pkg;

  localparam int unsigned VA_BITS   = 48;
  localparam int unsigned ADDR_BITS = 48;
  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

  // Entry bit positions.
  localparam int unsigned PRESENT_BIT = 0;
  localparam int unsigned LARGE_BIT   = 7;

  // Input beat kinds.
  localparam logic REQ_TRANSLATE = 1'b0;
  localparam logic REQ_RESPONSE  = 1'b1;

  // Output beat kinds.
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [63:0] table_base;
    logic [63:0] virt_addr;
    logic [63:0] entry_data;
    logic        read_error;
  } in_beat_t;

  typedef struct packed {
    logic                 out_kind;
    logic [ADDR_BITS-1:0] out_address;
    logic                 fault;
  } out_beat_t;

  // Classified operation handed from the front to the back.
  typedef enum logic [1:0] {
    OP_FAULT = 2'd0,
    OP_START = 2'd1,
    OP_RESP  = 2'd2
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [63:0]        data;
    logic [VA_BITS-1:0] vaddr;
    logic               rd_err;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Walk state: idle, or waiting for the entry of one of the four levels.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_L0   = 5'b00010,
    ST_L1   = 5'b00100,
    ST_L2   = 5'b01000,
    ST_L3   = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/pgw_front.sv =====
// Front end: classifies each input beat into an operation for the walk engine.
`timescale 1ns / 1ps
`default_nettype none

module pgw_front (
  input  pgw_pkg::in_beat_t beat_i,
  output pgw_pkg::work_t    work_o
);

  always_comb begin
    work_o.vaddr  = beat_i.virt_addr[pgw_pkg::VA_BITS-1:0];
    work_o.rd_err = beat_i.read_error;
    if (beat_i.req_type == pgw_pkg::REQ_TRANSLATE) begin
      work_o.data = beat_i.table_base;
      // A zero base or a zero address faults at once without a walk.
      if ((beat_i.table_base == 64'd0) || (beat_i.virt_addr == 64'd0)) begin
        work_o.op = pgw_pkg::OP_FAULT;
      end else begin
        work_o.op = pgw_pkg::OP_START;
      end
    end else begin
      work_o.data = beat_i.entry_data;
      work_o.op   = pgw_pkg::OP_RESP;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pgw_queue.sv =====
// Short FIFO that decouples the classifying front from the walk engine.
`timescale 1ns / 1ps
`default_nettype none

module pgw_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pgw_pkg::work_t    push_data_i,
  input  logic              pop_i,
  output pgw_pkg::work_t    pop_data_o,
  output pgw_pkg::q_stat_t  stat_o
);

  pgw_pkg::work_t                    mem_q [pgw_pkg::Q_DEPTH];
  logic [pgw_pkg::Q_PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [pgw_pkg::Q_PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [pgw_pkg::Q_CNT_W-1:0]       count_q, count_d;

  localparam logic [pgw_pkg::Q_PTR_W-1:0] LastPtr = pgw_pkg::Q_PTR_W'(pgw_pkg::Q_DEPTH - 1);
  localparam logic [pgw_pkg::Q_CNT_W-1:0] FullCnt = pgw_pkg::Q_CNT_W'(pgw_pkg::Q_DEPTH);

  assign stat_o.full  = (count_q == FullCnt);
  assign stat_o.empty = (count_q == '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pgw_back.sv =====
// Walk engine: holds the walk state, forms entry and page addresses, drives the output register.
`timescale 1ns / 1ps
`default_nettype none

module pgw_back #(
  parameter int unsigned PHYS_ADDR_BITS = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pgw_pkg::work_t     work_i,
  input  logic               take_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pgw_pkg::out_beat_t out_beat_o
);

  localparam logic [63:0] PhysMask = (64'd1 << PHYS_ADDR_BITS) - 64'd1;

  pgw_pkg::state_e                state_q, state_d;
  logic [pgw_pkg::VA_BITS-1:0]    vaddr_q, vaddr_d;
  logic                           out_valid_q, out_valid_d;
  pgw_pkg::out_beat_t             out_q, res;
  logic                           emit;
  logic [63:0]                    frame_full;
  logic [pgw_pkg::ADDR_BITS-1:0]  frame;

  assign ready_o     = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  assign frame_full = work_i.data & PhysMask;
  assign frame      = frame_full[pgw_pkg::ADDR_BITS-1:0];

  always_comb begin
    state_d         = state_q;
    vaddr_d         = vaddr_q;
    emit            = 1'b0;
    res.out_kind    = pgw_pkg::KIND_READ;
    res.out_address = '0;
    res.fault       = 1'b0;
    if (take_i) begin
      unique case (work_i.op)
        pgw_pkg::OP_FAULT: begin
          emit         = 1'b1;
          res.out_kind = pgw_pkg::KIND_DONE;
          res.fault    = 1'b1;
          state_d      = pgw_pkg::ST_IDLE;
        end
        pgw_pkg::OP_START: begin
          emit            = 1'b1;
          state_d         = pgw_pkg::ST_L0;
          vaddr_d         = work_i.vaddr;
          res.out_address = {frame[47:12], work_i.vaddr[47:39], 3'b000};
        end
        pgw_pkg::OP_RESP: begin
          if (state_q != pgw_pkg::ST_IDLE) begin
            emit = 1'b1;
            priority if (work_i.rd_err || !work_i.data[pgw_pkg::PRESENT_BIT]) begin
              res.out_kind = pgw_pkg::KIND_DONE;
              res.fault    = 1'b1;
              state_d      = pgw_pkg::ST_IDLE;
            end else if ((state_q == pgw_pkg::ST_L1) && work_i.data[pgw_pkg::LARGE_BIT]) begin
              res.out_kind    = pgw_pkg::KIND_DONE;
              res.out_address = {frame[47:30], vaddr_q[29:0]};
              state_d         = pgw_pkg::ST_IDLE;
            end else if ((state_q == pgw_pkg::ST_L2) && work_i.data[pgw_pkg::LARGE_BIT]) begin
              res.out_kind    = pgw_pkg::KIND_DONE;
              res.out_address = {frame[47:21], vaddr_q[20:0]};
              state_d         = pgw_pkg::ST_IDLE;
            end else if (state_q == pgw_pkg::ST_L3) begin
              res.out_kind    = pgw_pkg::KIND_DONE;
              res.out_address = {frame[47:12], vaddr_q[11:0]};
              state_d         = pgw_pkg::ST_IDLE;
            end else begin
              unique case (state_q)
                pgw_pkg::ST_L0: begin
                  state_d         = pgw_pkg::ST_L1;
                  res.out_address = {frame[47:12], vaddr_q[38:30], 3'b000};
                end
                pgw_pkg::ST_L1: begin
                  state_d         = pgw_pkg::ST_L2;
                  res.out_address = {frame[47:12], vaddr_q[29:21], 3'b000};
                end
                default: begin
                  state_d         = pgw_pkg::ST_L3;
                  res.out_address = {frame[47:12], vaddr_q[20:12], 3'b000};
                end
              endcase
            end
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (take_i && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pgw_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vaddr_q <= vaddr_d;
    if (take_i && emit) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/four_level_page_table_walker.sv =====
// Top level of the four-level page table walker.
`timescale 1ns / 1ps
`default_nettype none

// Four-level page table walker for x86-64 style tables with 4 KB, 2 MB and 1 GB
// pages. A translate beat (req_type 0) carries the table base and the virtual
// address; the walker answers with an entry read beat (out_kind 0) that names
// the PML4 entry address. Each response beat (req_type 1) that carries the
// entry, or a read error, moves the walk one level down and produces either the
// next entry read beat or a finished beat (out_kind 1) with the translated
// address. A clear present bit, a read error, or a zero base or virtual address
// finishes with address 0 and fault set. A large-page bit at the PDPT or PD
// level finishes with a 1 GB or 2 MB page. A translate beat during a walk drops
// that walk and starts the new one; a response beat with no walk in progress is
// consumed and gives no result. Every input beat produces at most one output
// beat, in order. The block takes one beat per clock cycle and returns one beat
// per cycle while the output is not stalled: a front classifier writes into a
// two-entry queue, and the walk engine reads one queued beat a cycle into the
// output register, so each result passes through the queue and then the output
// register before it is offered.
// The walk engine's output register sets the rate; it keeps running while the
// output is free or being taken, and the queue absorbs input while the output
// is stalled. PHYS_ADDR_BITS (36 to 52) sets which entry and base bits form a
// physical frame; output addresses are always 48 bits wide.
module four_level_page_table_walker #(
  parameter int unsigned PHYS_ADDR_BITS = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pgw_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pgw_pkg::out_beat_t out_beat_o
);

  pgw_pkg::work_t   front_work;
  pgw_pkg::work_t   queue_work;
  pgw_pkg::q_stat_t q_stat;
  logic             push;
  logic             pop;
  logic             back_ready;

  // The input is stalled only while the queue is full.
  assign in_stall_o = q_stat.full;
  assign push       = in_valid_i && !q_stat.full;
  assign pop        = !q_stat.empty && back_ready;

  pgw_front u_front (
    .beat_i (in_beat_i),
    .work_o (front_work)
  );

  pgw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_work),
    .pop_i       (pop),
    .pop_data_o  (queue_work),
    .stat_o      (q_stat)
  );

  pgw_back #(
    .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .work_i      (queue_work),
    .take_i      (pop),
    .ready_o     (back_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/pgw_checker.sv =====
// Port-level assertions for the page table walker, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module pgw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input pgw_pkg::out_beat_t out_beat_o
);

  // A stalled output beat stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("output beat changed while stalled");

  // A faulting translation always reports address zero.
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.fault |-> out_beat_o.out_address == '0)
    else $error("fault reported with nonzero address");

  // Entry read requests never carry a fault.
  a_read_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.out_kind == pgw_pkg::KIND_READ) |-> !out_beat_o.fault)
    else $error("entry read request flagged as fault");

  // Entry read addresses are eight-byte aligned.
  a_read_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.out_kind == pgw_pkg::KIND_READ)
      |-> out_beat_o.out_address[2:0] == 3'b000)
    else $error("entry read address not aligned");

endmodule

bind four_level_page_table_walker pgw_checker u_pgw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);

`default_nettype wire
